// File: src/adtt_pkg.sv
// shared types and constants for the adaptive device timing table
package adtt_pkg;

    localparam int unsigned DEVICES   = 16;
    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned DEV_W     = 4;
    localparam int unsigned GAMES_W   = 16;
    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned WAIT_W    = 22;
    localparam int unsigned CAP_W     = 16;
    localparam int unsigned TPG_W     = 40;
    localparam int unsigned OUTST_W   = 32;
    localparam int unsigned ACC_W     = 30;
    localparam int unsigned UNIT_W    = 42;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WAIT_W-1:0] MAX_WAIT      = 22'd3600000;
    localparam logic [WAIT_W-1:0] HALF_MAX_WAIT = 22'd1800000;
    localparam logic [WAIT_W-1:0] BASE_WAIT     = 22'd60000;
    localparam logic [WAIT_W-1:0] LEASE_RESET   = 22'd60000;
    localparam logic [ACC_W-1:0]  MUL_BOUND     = 30'd906240000;

    localparam logic [CNT_W-1:0] DIV_STEPS_M1 = 6'd39;
    localparam logic [CNT_W-1:0] MUL_STEPS_M1 = 6'd32;

    localparam logic [2:0] OP_DISPATCH  = 3'd0;
    localparam logic [2:0] OP_DELIVERY  = 3'd1;
    localparam logic [2:0] OP_TIMEOUT   = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_WAIT_QRY  = 3'd4;
    localparam logic [2:0] OP_CAP_QRY   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_ITER,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [OUTST_W-1:0] games_open;
        logic               silent_flag;
        logic [WAIT_W-1:0]  prev_wait;
        logic [CAP_W-1:0]   adaptive_capacity;
        logic [CAP_W-1:0]   declared_limit;
        logic [TPG_W-1:0]   time_per_game;
    } entry_t;

endpackage

// File: src/adaptive_device_timing_table.sv
// adaptive device timing table: per-device capacity and wait estimator
// requests without iteration go through read, execute and finish to result or write-back
// wait query with a time estimate: 33 steps of the shared unit
// delivery with games: 40 steps of the same unit as a divider
// one request at a time, taken only in idle; a held result stalls the finish step
// reset: per-entry valid bits clear at once, unwritten entries read as zero, no clearing pass
module adaptive_device_timing_table
    import adtt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TPG_W-1:0]     cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_operation,
    input  logic [DEV_W-1:0]     s_device,
    input  logic [GAMES_W-1:0]   s_game_count,
    input  logic [ELAPSED_W-1:0] s_elapsed_time,
    input  logic                 s_peer_active,
    input  logic [WAIT_W-1:0]    s_waited_time,
    input  logic [CAP_W-1:0]     s_declared_capacity,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WAIT_W-1:0]    m_wait_time,
    output logic [CAP_W-1:0]     m_capacity
);

    state_t state_reg, state_next;

    logic [TPG_W-1:0]     seed_reg;
    logic [WAIT_W-1:0]    lease_reg;
    logic [DEVICES-1:0]   valid_reg;
    entry_t               mem [DEVICES];

    logic [2:0]           op_reg;
    logic [DEV_W-1:0]     dev_reg;
    logic [GAMES_W-1:0]   games_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 active_reg;
    logic [WAIT_W-1:0]    waited_reg;
    logic [CAP_W-1:0]     decl_reg;
    entry_t               entry_reg;

    logic [TPG_W-1:0]     q_reg, q_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg;

    logic                 m_valid_reg;
    logic [WAIT_W-1:0]    m_wait_reg;
    logic [CAP_W-1:0]     m_cap_reg;

    logic                 accept;
    logic                 out_free;
    logic                 has_result;
    logic                 mem_we;
    logic                 out_load;
    logic                 need_iter;
    logic [CNT_W-1:0]     iter_len;

    logic [TPG_W-1:0]     t_sel;
    logic [TPG_W:0]       p_val;
    logic [OUTST_W:0]     n_val;

    logic                 unit_sub;
    logic [UNIT_W-1:0]    unit_a, unit_b;
    logic [UNIT_W:0]      unit_sum;
    logic [GAMES_W-1:0]   rem_next;

    entry_t               entry_new;
    logic [WAIT_W-1:0]    res_wait;
    logic [CAP_W-1:0]     res_cap;
    logic [OUTST_W:0]     add_sum;
    logic [OUTST_W-1:0]   sub_val;
    logic [TPG_W:0]       tpg_sum;
    logic [CAP_W-1:0]     cap_base;
    logic [CAP_W-1:0]     decl_eff;
    logic [WAIT_W:0]      raw_wait;
    logic [WAIT_W:0]      lo_wait;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign m_valid     = m_valid_reg;
    assign m_wait_time = m_wait_reg;
    assign m_capacity  = m_cap_reg;

    // operands used by setup and iteration
    assign t_sel = (entry_reg.time_per_game != '0) ? entry_reg.time_per_game : seed_reg;
    assign p_val = {t_sel, 1'b0};
    assign n_val = {1'b0, entry_reg.games_open}
                 + {{(OUTST_W + 1 - GAMES_W){1'b0}}, games_reg};

    assign has_result = (op_reg == OP_WAIT_QRY) || (op_reg == OP_CAP_QRY);

    always_comb begin
        need_iter = 1'b0;
        iter_len  = DIV_STEPS_M1;
        if (op_reg == OP_DELIVERY) begin
            need_iter = (games_reg != '0);
        end else if (op_reg == OP_WAIT_QRY) begin
            need_iter = !entry_reg.silent_flag && (t_sel != '0);
            iter_len  = MUL_STEPS_M1;
        end
    end

    // shared add/subtract unit
    always_comb begin
        if (op_reg == OP_DELIVERY) begin
            unit_sub = 1'b1;
            unit_a   = {{(UNIT_W - GAMES_W - 1){1'b0}}, acc_reg[GAMES_W-1:0], q_reg[TPG_W-1]};
            unit_b   = {{(UNIT_W - GAMES_W){1'b0}}, games_reg};
        end else begin
            unit_sub = 1'b0;
            unit_a   = {{(UNIT_W - ACC_W - 1){1'b0}}, acc_reg, 1'b0};
            unit_b   = q_reg[TPG_W-1] ? {{(UNIT_W - TPG_W - 1){1'b0}}, p_val} : '0;
        end
        unit_sum = {1'b0, unit_a} + {1'b0, unit_b ^ {UNIT_W{unit_sub}}}
                 + {{UNIT_W{1'b0}}, unit_sub};
    end

    always_comb begin
        rem_next = unit_sum[UNIT_W] ? unit_sum[GAMES_W-1:0] : unit_a[GAMES_W-1:0];
        if (op_reg == OP_DELIVERY) begin
            acc_next = {{(ACC_W - GAMES_W){1'b0}}, rem_next};
            q_next   = {q_reg[TPG_W-2:0], unit_sum[UNIT_W]};
        end else begin
            if (unit_sum[UNIT_W-1:0] >= {{(UNIT_W - ACC_W){1'b0}}, MUL_BOUND}) begin
                acc_next = MUL_BOUND;
            end else begin
                acc_next = unit_sum[ACC_W-1:0];
            end
            q_next = {q_reg[TPG_W-2:0], 1'b0};
        end
    end

    // entry update and result
    always_comb begin
        entry_new = entry_reg;
        res_wait  = '0;
        res_cap   = '0;
        add_sum   = {1'b0, entry_reg.games_open}
                  + {{(OUTST_W + 1 - GAMES_W){1'b0}}, games_reg};
        sub_val   = (entry_reg.games_open > {{(OUTST_W - GAMES_W){1'b0}}, games_reg})
                  ? entry_reg.games_open - {{(OUTST_W - GAMES_W){1'b0}}, games_reg}
                  : '0;
        tpg_sum   = {1'b0, entry_reg.time_per_game} + {1'b0, q_reg};
        cap_base  = (entry_reg.adaptive_capacity != '0) ? entry_reg.adaptive_capacity
                                                        : entry_reg.declared_limit;
        decl_eff  = (decl_reg == '0) ? {{(CAP_W - 1){1'b0}}, 1'b1} : decl_reg;
        raw_wait  = {1'b0, lease_reg};
        if (!entry_reg.silent_flag) begin
            if (t_sel != '0) begin
                if (acc_reg >= MUL_BOUND) begin
                    raw_wait = {1'b0, MAX_WAIT};
                end else begin
                    raw_wait = {1'b0, acc_reg[ACC_W-1:FRAC_BITS]} + {1'b0, BASE_WAIT};
                end
            end else if (entry_reg.prev_wait != '0) begin
                if (entry_reg.prev_wait > HALF_MAX_WAIT) begin
                    raw_wait = {1'b0, MAX_WAIT};
                end else begin
                    raw_wait = {entry_reg.prev_wait, 1'b0};
                end
            end
        end
        lo_wait = (raw_wait < {1'b0, lease_reg}) ? {1'b0, lease_reg} : raw_wait;

        case (op_reg)
            OP_DISPATCH: begin
                entry_new.games_open = add_sum[OUTST_W] ? '1 : add_sum[OUTST_W-1:0];
            end
            OP_DELIVERY: begin
                entry_new.silent_flag = 1'b0;
                entry_new.prev_wait   = '0;
                entry_new.games_open  = sub_val;
                if ((entry_reg.adaptive_capacity != '0) &&
                    (entry_reg.adaptive_capacity < entry_reg.declared_limit)) begin
                    entry_new.adaptive_capacity = entry_reg.adaptive_capacity + 1'b1;
                end
                if ((games_reg != '0) && (q_reg != '0)) begin
                    entry_new.time_per_game = (entry_reg.time_per_game != '0)
                                            ? tpg_sum[TPG_W:1] : q_reg;
                end
            end
            OP_TIMEOUT: begin
                entry_new.games_open        = sub_val;
                entry_new.silent_flag       = !active_reg;
                entry_new.prev_wait         = active_reg ? waited_reg : '0;
                entry_new.adaptive_capacity = (cap_base > {{(CAP_W - 1){1'b0}}, 1'b1})
                                            ? {1'b0, cap_base[CAP_W-1:1]}
                                            : {{(CAP_W - 1){1'b0}}, 1'b1};
            end
            OP_CLEAR: begin
                entry_new.games_open        = '0;
                entry_new.silent_flag       = 1'b0;
                entry_new.prev_wait         = '0;
                entry_new.adaptive_capacity = '0;
            end
            OP_WAIT_QRY: begin
                res_wait = (lo_wait > {1'b0, MAX_WAIT}) ? MAX_WAIT : lo_wait[WAIT_W-1:0];
            end
            OP_CAP_QRY: begin
                entry_new.declared_limit = decl_eff;
                if ((entry_reg.adaptive_capacity == '0) ||
                    (entry_reg.adaptive_capacity > decl_eff)) begin
                    entry_new.adaptive_capacity = decl_eff;
                end
                res_cap = entry_new.adaptive_capacity;
            end
            default: begin
                entry_new = entry_reg;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = need_iter ? ST_ITER : ST_FINISH;
            end
            ST_ITER: begin
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!has_result || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready  = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_FINISH: begin
                mem_we   = 1'b1;
                out_load = has_result && out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            seed_reg    <= '0;
            lease_reg   <= LEASE_RESET;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                valid_reg[dev_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SEED) begin
                    seed_reg <= cfg_data;
                end else if (cfg_index == CFG_LEASE) begin
                    lease_reg <= cfg_data[WAIT_W-1:0];
                end
            end
        end
    end

    // entry store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[dev_reg] <= entry_new;
        end
        if (state_reg == ST_READ) begin
            entry_reg <= valid_reg[dev_reg] ? mem[dev_reg] : '0;
        end
    end

    // request capture, iteration and result registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= s_operation;
            dev_reg     <= s_device;
            games_reg   <= s_game_count;
            elapsed_reg <= s_elapsed_time;
            active_reg  <= s_peer_active;
            waited_reg  <= s_waited_time;
            decl_reg    <= s_declared_capacity;
        end
        if (state_reg == ST_EXEC) begin
            acc_reg <= '0;
            cnt_reg <= iter_len;
            if (op_reg == OP_DELIVERY) begin
                q_reg <= {elapsed_reg, {FRAC_BITS{1'b0}}};
            end else begin
                q_reg <= {n_val, {(TPG_W - OUTST_W - 1){1'b0}}};
            end
        end else if (state_reg == ST_ITER) begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (out_load) begin
            m_wait_reg <= res_wait;
            m_cap_reg  <= res_cap;
        end
    end

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_READ))
        else $error("accepted request did not start an entry read");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ITER) && (op_reg == OP_DELIVERY)) |->
            (acc_reg[GAMES_W-1:0] < games_reg))
        else $error("divider remainder not below divisor");

    a_acc_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ITER) && (op_reg == OP_WAIT_QRY)) |-> (acc_reg <= MUL_BOUND))
        else $error("multiply accumulator above saturation bound");

    a_cnt_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ITER) && (cnt_reg != '0)) |=>
            ((state_reg == ST_ITER) && (cnt_reg == $past(cnt_reg) - 1'b1)))
        else $error("iteration counter skipped a step");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

endmodule
